// ===== sv/rvi_pkg.sv =====
package rvi_pkg;

    localparam int PROD_W      = 64;
    localparam int ROOT_W      = 32;
    localparam int LEG_W       = 48;
    localparam int OUT_W       = 23;
    localparam int PERIOD_W    = 11;
    localparam int WINDOW_W    = 9;
    localparam int UNSTABLE_W  = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int FRAC_SHIFT  = 8;
    localparam int SIG_W       = ROOT_W + FRAC_SHIFT;
    localparam int PERIOD_MIN  = 1;
    localparam int PERIOD_MAX  = 1024;
    localparam int WINDOW_MIN  = 2;

    localparam logic [OUT_W-1:0] HUNDRED_FIX = 23'd6553600;
    localparam logic [OUT_W-1:0] FIFTY_FIX   = 23'd3276800;

    localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = 11'd14;
    localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 9'd10;
    localparam logic [UNSTABLE_W-1:0] UNSTABLE_RESET = 16'd0;

    typedef logic [PROD_W-1:0] word_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PERIOD   = 2'd0,
        CFG_WINDOW   = 2'd1,
        CFG_UNSTABLE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic start;
        word_t op_a;
        word_t op_b;
    } unit_req_t;

endpackage

// ===== sv/rvi_if.sv =====
interface rvi_sample_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface rvi_result_if;
    logic        valid;
    logic        ready;
    logic [22:0] rvi_value;

    modport source (output valid, output rvi_value, input ready);
    modport sink (input valid, input rvi_value, output ready);
endinterface

// ===== sv/rvi_mul.sv =====
module rvi_mul
    import rvi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  unit_req_t req,
    output logic      done,
    output word_t     product
);

    word_t a_reg, a_next;
    word_t b_reg, b_next;
    word_t acc_reg, acc_next;
    logic  busy_reg, busy_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            a_next    = req.op_a;
            b_next    = req.op_b;
            acc_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_next = acc_reg + a_reg;
                end
                a_next = {a_reg[PROD_W-2:0], 1'b0};
                b_next = {1'b0, b_reg[PROD_W-1:1]};
            end
        end
    end

    assign done    = busy_reg && (b_reg == '0);
    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

endmodule

// ===== sv/rvi_div.sv =====
module rvi_div
    import rvi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  unit_req_t req,
    output logic      done,
    output word_t     quotient
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W:0]   rem_reg, rem_next;
    word_t             quo_reg, quo_next;
    word_t             div_reg, div_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [PROD_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[PROD_W-1:0], quo_reg[PROD_W-1]};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.op_a;
            div_next  = req.op_b;
            cnt_next  = CNT_W'(PROD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (trial >= {1'b0, div_reg})
                begin
                    rem_next = trial - {1'b0, div_reg};
                    quo_next = {quo_reg[PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[PROD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

endmodule

// ===== sv/rvi_sqrt.sv =====
module rvi_sqrt
    import rvi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  word_t             radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 2;

    word_t              rad_reg, rad_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [REM_W+1:0]   trial;
    logic [REM_W+1:0]   test;

    always_comb
    begin
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, rad_reg[PROD_W-1:PROD_W-2]};
        test      = {2'b00, root_reg, 2'b01};
        if (start)
        begin
            rad_next  = radicand;
            root_next = '0;
            rem_next  = '0;
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (trial >= test)
                begin
                    rem_next  = REM_W'(trial - test);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = REM_W'(trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_next = {rad_reg[PROD_W-3:0], 2'b00};
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign root = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

endmodule

// ===== sv/relative_volatility_index.sv =====
// channel     | dir | payload                      | transaction
// sample_ch   | in  | sample, signed SAMPLE_BITS   | valid & ready
// result_ch   | out | rvi_value, 23 bits unsigned  | valid & ready
// cfg         | in  | cfg_index, cfg_wdata         | cfg_we high
//
// For each sample, up to seven products, four quotients and one root run one after another;
// a product ends once its second operand has been shifted out.
// Reset and a write to the period, window or unstable register clear the window sums,
// counters and legs.
// A result waits in the output register while the next sample is taken; the sequencer
// stalls only when a new result meets a full output register.
module relative_volatility_index
    import rvi_pkg::*;
#(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    rvi_sample_if.sink             sample_ch,
    rvi_result_if.source           result_ch
);

    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int D_W    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + PTR_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1 + PTR_W;
    localparam int WARM_W = $clog2(MAX_WINDOW + PERIOD_MAX + (1 << UNSTABLE_W));

    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_READ    = 17'h00002,
        S_SQ_OLD  = 17'h00004,
        S_SQ_NEW  = 17'h00008,
        S_MUL_DS2 = 17'h00010,
        S_MUL_MAG = 17'h00020,
        S_SQRT    = 17'h00040,
        S_DIV_SIG = 17'h00080,
        S_MUL_UP  = 17'h00100,
        S_DIV_UP  = 17'h00200,
        S_MUL_DN  = 17'h00400,
        S_DIV_DN  = 17'h00800,
        S_CHECK   = 17'h01000,
        S_MUL_OUT = 17'h02000,
        S_DIV_OUT = 17'h04000,
        S_EMIT    = 17'h08000,
        S_FINISH  = 17'h10000
    } state_t;

    state_t state_reg, state_next;
    logic   launched_reg, launched_next;

    logic [PERIOD_W-1:0]   period_reg;
    logic [WINDOW_W-1:0]   window_reg;
    logic [UNSTABLE_W-1:0] unstable_reg;

    logic [PTR_W-1:0]              ptr_reg, ptr_next;
    logic signed [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic [SQ_W-1:0]               sq_reg, sq_next;
    logic [WARM_W-1:0]             bars_reg, bars_next;
    logic [LEG_W-1:0]              up_reg, up_next;
    logic [LEG_W-1:0]              dn_reg, dn_next;

    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    word_t                         num_reg, num_next;
    logic [ROOT_W-1:0]             root_reg, root_next;
    logic [SIG_W-1:0]              sigma_reg, sigma_next;
    word_t                         acc_reg, acc_next;
    logic [OUT_W-1:0]              val_reg, val_next;
    logic                          smooth_reg, smooth_next;

    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    logic signed [SAMPLE_BITS-1:0] window_mem [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic                          mem_we;

    logic [D_W-1:0]         d_eff;
    logic [PERIOD_W-1:0]    p_eff;
    logic [WARM_W-1:0]      warm_end;
    logic [WARM_W-1:0]      k_bar;
    logic                   n_ge_d;
    logic                   n_ge_dm1;
    logic                   seed;
    logic                   seed_last;
    logic                   emit_due;
    logic                   rise;
    logic                   fall;
    logic [SAMPLE_BITS-1:0] s_mag;
    logic [SAMPLE_BITS-1:0] old_mag;
    logic [SUM_W-1:0]       sum_mag;
    word_t                  total;
    word_t                  upv;
    word_t                  dnv;
    logic [SIG_W-1:0]       sig_now;
    logic [LEG_W-1:0]       up_add;
    logic [LEG_W-1:0]       dn_add;
    logic                   cfg_hit;

    unit_req_t         mul_req;
    unit_req_t         div_req;
    logic              mul_done;
    logic              div_done;
    logic              sqrt_start;
    logic              sqrt_done;
    word_t             mul_prod;
    word_t             div_quo;
    logic [ROOT_W-1:0] sqrt_root;

    rvi_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_prod)
    );

    rvi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    rvi_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (num_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb
    begin
        if (window_reg < WINDOW_W'(WINDOW_MIN))
        begin
            d_eff = D_W'(WINDOW_MIN);
        end
        else if (32'(window_reg) > MAX_WINDOW)
        begin
            d_eff = D_W'(MAX_WINDOW);
        end
        else
        begin
            d_eff = D_W'(window_reg);
        end
        if (period_reg < PERIOD_W'(PERIOD_MIN))
        begin
            p_eff = PERIOD_W'(PERIOD_MIN);
        end
        else if (period_reg > PERIOD_W'(PERIOD_MAX))
        begin
            p_eff = PERIOD_W'(PERIOD_MAX);
        end
        else
        begin
            p_eff = period_reg;
        end
    end

    assign warm_end  = WARM_W'(d_eff) + WARM_W'(p_eff) + WARM_W'(unstable_reg) - WARM_W'(2);
    assign n_ge_d    = bars_reg >= WARM_W'(d_eff);
    assign n_ge_dm1  = bars_reg >= (WARM_W'(d_eff) - WARM_W'(1));
    assign k_bar     = bars_reg - (WARM_W'(d_eff) - WARM_W'(1));
    assign seed      = k_bar < WARM_W'(p_eff);
    assign seed_last = k_bar == (WARM_W'(p_eff) - WARM_W'(1));
    assign emit_due  = bars_reg >= warm_end;

    assign rise    = sample_reg > prev_reg;
    assign fall    = sample_reg < prev_reg;
    assign s_mag   = sample_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_reg)
                                               : SAMPLE_BITS'(sample_reg);
    assign old_mag = rd_data_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-rd_data_reg)
                                                : SAMPLE_BITS'(rd_data_reg);
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign total   = PROD_W'(up_reg) + PROD_W'(dn_reg);
    assign upv     = rise ? PROD_W'(sigma_reg) : '0;
    assign dnv     = fall ? PROD_W'(sigma_reg) : '0;
    assign sig_now = div_quo[SIG_W-1:0];
    assign up_add  = rise ? LEG_W'(sig_now) : '0;
    assign dn_add  = fall ? LEG_W'(sig_now) : '0;
    assign cfg_hit = cfg_we && (cfg_index == CFG_PERIOD || cfg_index == CFG_WINDOW
                                || cfg_index == CFG_UNSTABLE);

    assign sample_ch.ready = (state_reg == S_IDLE);
    assign result_ch.valid     = out_valid_reg;
    assign result_ch.rvi_value = out_data_reg;

    always_comb
    begin
        mul_req    = '0;
        div_req    = '0;
        sqrt_start = 1'b0;
        case (state_reg)
            S_SQ_OLD:
            begin
                mul_req.op_a = PROD_W'(old_mag);
                mul_req.op_b = PROD_W'(old_mag);
                mul_req.start = !launched_reg;
            end
            S_SQ_NEW:
            begin
                mul_req.op_a = PROD_W'(s_mag);
                mul_req.op_b = PROD_W'(s_mag);
                mul_req.start = !launched_reg;
            end
            S_MUL_DS2:
            begin
                mul_req.op_a = PROD_W'(sq_reg);
                mul_req.op_b = PROD_W'(d_eff);
                mul_req.start = !launched_reg;
            end
            S_MUL_MAG:
            begin
                mul_req.op_a = PROD_W'(sum_mag);
                mul_req.op_b = PROD_W'(sum_mag);
                mul_req.start = !launched_reg;
            end
            S_SQRT:
            begin
                sqrt_start = !launched_reg;
            end
            S_DIV_SIG:
            begin
                div_req.op_a = PROD_W'({root_reg, FRAC_SHIFT'(0)});
                div_req.op_b = PROD_W'(d_eff);
                div_req.start = !launched_reg;
            end
            S_MUL_UP:
            begin
                mul_req.op_a = PROD_W'(up_reg);
                mul_req.op_b = PROD_W'(p_eff - PERIOD_W'(1));
                mul_req.start = !launched_reg;
            end
            S_MUL_DN:
            begin
                mul_req.op_a = PROD_W'(dn_reg);
                mul_req.op_b = PROD_W'(p_eff - PERIOD_W'(1));
                mul_req.start = !launched_reg;
            end
            S_DIV_UP, S_DIV_DN:
            begin
                div_req.op_a = acc_reg;
                div_req.op_b = PROD_W'(p_eff);
                div_req.start = !launched_reg;
            end
            S_MUL_OUT:
            begin
                mul_req.op_a = PROD_W'(up_reg);
                mul_req.op_b = PROD_W'(HUNDRED_FIX);
                mul_req.start = !launched_reg;
            end
            S_DIV_OUT:
            begin
                div_req.op_a = acc_reg;
                div_req.op_b = total;
                div_req.start = !launched_reg;
            end
            default:
            begin
                mul_req    = '0;
                div_req    = '0;
                sqrt_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        launched_next  = launched_reg;
        ptr_next       = ptr_reg;
        prev_next      = prev_reg;
        sum_next       = sum_reg;
        sq_next        = sq_reg;
        bars_next      = bars_reg;
        up_next        = up_reg;
        dn_next        = dn_reg;
        sample_next    = sample_reg;
        num_next       = num_reg;
        root_next      = root_reg;
        sigma_next     = sigma_reg;
        acc_next       = acc_reg;
        val_next       = val_reg;
        smooth_next    = smooth_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;

        if (out_valid_reg && result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (mul_req.start || div_req.start || sqrt_start)
        begin
            launched_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample_ch.valid)
                begin
                    sample_next = sample_ch.sample;
                    if (D_W'(ptr_reg) >= d_eff)
                    begin
                        ptr_next = '0;
                    end
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = n_ge_d ? S_SQ_OLD : S_SQ_NEW;
            end
            S_SQ_OLD:
            begin
                if (mul_done)
                begin
                    sq_next       = sq_reg - SQ_W'(mul_prod);
                    sum_next      = sum_reg - SUM_W'(rd_data_reg);
                    launched_next = 1'b0;
                    state_next    = S_SQ_NEW;
                end
            end
            S_SQ_NEW:
            begin
                if (mul_done)
                begin
                    sq_next  = sq_reg + SQ_W'(mul_prod);
                    sum_next = sum_reg + SUM_W'(sample_reg);
                    mem_we   = 1'b1;
                    if ((D_W'(ptr_reg) + D_W'(1)) >= d_eff)
                    begin
                        ptr_next = '0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + PTR_W'(1);
                    end
                    launched_next = 1'b0;
                    state_next    = n_ge_dm1 ? S_MUL_DS2 : S_FINISH;
                end
            end
            S_MUL_DS2:
            begin
                if (mul_done)
                begin
                    num_next      = mul_prod;
                    launched_next = 1'b0;
                    state_next    = S_MUL_MAG;
                end
            end
            S_MUL_MAG:
            begin
                if (mul_done)
                begin
                    num_next      = num_reg - mul_prod;
                    launched_next = 1'b0;
                    state_next    = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    root_next     = sqrt_root;
                    launched_next = 1'b0;
                    state_next    = S_DIV_SIG;
                end
            end
            S_DIV_SIG:
            begin
                if (div_done)
                begin
                    sigma_next    = sig_now;
                    launched_next = 1'b0;
                    if (seed)
                    begin
                        up_next     = up_reg + up_add;
                        dn_next     = dn_reg + dn_add;
                        smooth_next = 1'b0;
                        if (seed_last)
                        begin
                            acc_next   = PROD_W'(LEG_W'(up_reg + up_add));
                            state_next = S_DIV_UP;
                        end
                        else
                        begin
                            state_next = S_CHECK;
                        end
                    end
                    else
                    begin
                        smooth_next = 1'b1;
                        state_next  = S_MUL_UP;
                    end
                end
            end
            S_MUL_UP:
            begin
                if (mul_done)
                begin
                    acc_next      = mul_prod + upv;
                    launched_next = 1'b0;
                    state_next    = S_DIV_UP;
                end
            end
            S_DIV_UP:
            begin
                if (div_done)
                begin
                    up_next       = div_quo[LEG_W-1:0];
                    launched_next = 1'b0;
                    if (smooth_reg)
                    begin
                        state_next = S_MUL_DN;
                    end
                    else
                    begin
                        acc_next   = PROD_W'(dn_reg);
                        state_next = S_DIV_DN;
                    end
                end
            end
            S_MUL_DN:
            begin
                if (mul_done)
                begin
                    acc_next      = mul_prod + dnv;
                    launched_next = 1'b0;
                    state_next    = S_DIV_DN;
                end
            end
            S_DIV_DN:
            begin
                if (div_done)
                begin
                    dn_next       = div_quo[LEG_W-1:0];
                    launched_next = 1'b0;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!emit_due)
                begin
                    state_next = S_FINISH;
                end
                else if (total == '0)
                begin
                    val_next   = FIFTY_FIX;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_MUL_OUT;
                end
            end
            S_MUL_OUT:
            begin
                if (mul_done)
                begin
                    acc_next      = mul_prod;
                    launched_next = 1'b0;
                    state_next    = S_DIV_OUT;
                end
            end
            S_DIV_OUT:
            begin
                if (div_done)
                begin
                    val_next      = div_quo[OUT_W-1:0];
                    launched_next = 1'b0;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = val_reg;
                    state_next     = S_FINISH;
                end
            end
            S_FINISH:
            begin
                prev_next = sample_reg;
                if (bars_reg <= warm_end)
                begin
                    bars_next = bars_reg + WARM_W'(1);
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_hit)
        begin
            ptr_next  = '0;
            prev_next = '0;
            sum_next  = '0;
            sq_next   = '0;
            bars_next = '0;
            up_next   = '0;
            dn_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launched_reg  <= 1'b0;
            period_reg    <= PERIOD_RESET;
            window_reg    <= WINDOW_RESET;
            unstable_reg  <= UNSTABLE_RESET;
            ptr_reg       <= '0;
            prev_reg      <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            bars_reg      <= '0;
            up_reg        <= '0;
            dn_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            ptr_reg       <= ptr_next;
            prev_reg      <= prev_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            bars_reg      <= bars_next;
            up_reg        <= up_next;
            dn_reg        <= dn_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PERIOD:   period_reg   <= cfg_wdata[PERIOD_W-1:0];
                    CFG_WINDOW:   window_reg   <= cfg_wdata[WINDOW_W-1:0];
                    CFG_UNSTABLE: unstable_reg <= cfg_wdata[UNSTABLE_W-1:0];
                    default:      period_reg   <= period_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        num_reg      <= num_next;
        root_reg     <= root_next;
        sigma_reg    <= sigma_next;
        acc_reg      <= acc_next;
        val_reg      <= val_next;
        smooth_reg   <= smooth_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            window_mem[ptr_reg] <= sample_reg;
        end
        rd_data_reg <= window_mem[ptr_reg];
    end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    import rvi_pkg::*;

    localparam int               HALF_PERIOD   = 2;
    localparam int               SETTLE_CYCLES = 1200;
    localparam longint           CYCLE_LIMIT   = 6_000_000;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint           SAMPLE_MAX    = 8388607;
    localparam longint           SAMPLE_MIN    = -8388608;

    class rvi_scoreboard;
        logic [PERIOD_W-1:0]   period_reg;
        logic [WINDOW_W-1:0]   window_reg;
        logic [UNSTABLE_W-1:0] unstable_reg;
        logic [23:0]           history [256];
        int unsigned           head;
        longint                last_price;
        longint                price_sum;
        longint unsigned       price_sq_sum;
        longint unsigned       bar_count;
        longint unsigned       rise_leg;
        longint unsigned       fall_leg;
        logic [OUT_W-1:0]      rvi_queue [$];
        int                    errors;
        int                    matched;

        function new();
            period_reg   = PERIOD_RESET;
            window_reg   = WINDOW_RESET;
            unstable_reg = UNSTABLE_RESET;
            errors       = 0;
            matched      = 0;
            clear();
        endfunction

        function void clear();
            foreach (history[i]) history[i] = '0;
            head         = 0;
            last_price   = 0;
            price_sum    = 0;
            price_sq_sum = 0;
            bar_count    = 0;
            rise_leg     = 0;
            fall_leg     = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_PERIOD) period_reg = val[PERIOD_W-1:0];
            else if (idx == CFG_WINDOW) window_reg = val[WINDOW_W-1:0];
            else if (idx == CFG_UNSTABLE) unstable_reg = val;
            else return;
            clear();
        endfunction

        function longint unsigned int_root(longint unsigned x);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= x && t <= 64'hFFFF_FFFF) r = t;
            end
            return r;
        endfunction

        function void take_sample(logic signed [23:0] price);
            longint unsigned d, p, warm_end, n, k, mag, num, sigma, up_in, dn_in, total;
            longint          s, old;
            d = (window_reg < WINDOW_MIN) ? WINDOW_MIN : (window_reg > 256) ? 256 : window_reg;
            p = (period_reg < PERIOD_MIN) ? PERIOD_MIN :
                (period_reg > PERIOD_MAX) ? PERIOD_MAX : period_reg;
            warm_end = (d - 1) + (p - 1) + unstable_reg;
            n = bar_count;
            s = price;
            if (head >= d) head = 0;
            if (n >= d) begin
                old = longint'(signed'(history[head]));
                price_sum -= old;
                price_sq_sum -= longint'(old * old);
            end
            history[head] = price;
            head = (head + 1 >= d) ? 0 : head + 1;
            price_sum += s;
            price_sq_sum += longint'(s * s);
            if (n >= d - 1) begin
                k = n - (d - 1);
                mag = (price_sum < 0) ? longint'(-price_sum) : longint'(price_sum);
                num = d * price_sq_sum - mag * mag;
                sigma = (int_root(num) << 8) / d;
                up_in = 0;
                dn_in = 0;
                if (s > last_price) up_in = sigma;
                else if (s < last_price) dn_in = sigma;
                if (k < p) begin
                    rise_leg = (rise_leg + up_in) & 64'hFFFF_FFFF_FFFF;
                    fall_leg = (fall_leg + dn_in) & 64'hFFFF_FFFF_FFFF;
                    if (k == p - 1) begin
                        rise_leg /= p;
                        fall_leg /= p;
                    end
                end else begin
                    rise_leg = ((up_in + (p - 1) * rise_leg) / p) & 64'hFFFF_FFFF_FFFF;
                    fall_leg = ((dn_in + (p - 1) * fall_leg) / p) & 64'hFFFF_FFFF_FFFF;
                end
                if (n >= warm_end) begin
                    total = rise_leg + fall_leg;
                    if (total == 0) rvi_queue.push_back(FIFTY_FIX);
                    else rvi_queue.push_back(OUT_W'((rise_leg * 64'(HUNDRED_FIX)) / total));
                end
            end
            last_price = s;
            if (n <= warm_end) bar_count = n + 1;
        endfunction

        function void check_result(logic [OUT_W-1:0] actual);
            logic [OUT_W-1:0] want;
            if (rvi_queue.size() == 0) begin
                $display("%0t: unexpected rvi_value, expected none, actual %0d", $time, actual);
                errors++;
                return;
            end
            want = rvi_queue.pop_front();
            if (actual !== want) begin
                $display("%0t: rvi_value mismatch, expected %0d, actual %0d",
                         $time, want, actual);
                errors++;
            end else begin
                matched++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    longint                 cycles;
    longint                 walk_price;
    int                     items_sent;
    bit                     tx_burst;
    rvi_scoreboard          sb;

    rvi_sample_if #(.SAMPLE_BITS(24)) sample_ch ();
    rvi_result_if                     result_ch ();

    relative_volatility_index #(
        .MAX_WINDOW  (256),
        .SAMPLE_BITS (24)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample_ch (sample_ch.sink),
        .result_ch (result_ch.source)
    );

    always #HALF_PERIOD clk = ~clk;

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_PERIOD;
        cfg_wdata          = '0;
        sample_ch.valid    = 1'b0;
        sample_ch.sample   = '0;
        result_ch.ready    = 1'b0;
        sb                 = new();
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial cycles = 0;

    always
    begin : result_sink
        int  gap;
        bit  rx_burst;
        rx_burst = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 40) == 0) rx_burst = ~rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid === 1'b1));
            sb.check_result(result_ch.rvi_value);
        end
    end

    task automatic send_sample(input longint price);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= 24'(price);
        do @(posedge clk); while (!(sample_ch.ready === 1'b1));
        sb.take_sample(24'(price));
        items_sent++;
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (sb.rvi_queue.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_register(idx, val);
        @(posedge clk);
    endtask

    function automatic longint next_price();
        longint step;
        if ($urandom_range(0, 9) < 3) begin
            walk_price = longint'(signed'(24'($urandom())));
        end else begin
            if ($urandom_range(0, 6) == 0) step = 0;
            else step = longint'($urandom_range(0, 2048)) - 1024;
            walk_price += step;
            if (walk_price > SAMPLE_MAX) walk_price = SAMPLE_MAX;
            if (walk_price < SAMPLE_MIN) walk_price = SAMPLE_MIN;
        end
        return walk_price;
    endfunction

    task automatic run_phase(input int count);
        tx_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 60) == 0) tx_burst = ~tx_burst;
            send_sample(next_price());
        end
    endtask

    task automatic configure(input int period, input int window, input int unstable);
        write_register(CFG_PERIOD, CFG_DATA_W'(period));
        write_register(CFG_WINDOW, CFG_DATA_W'(window));
        write_register(CFG_UNSTABLE, CFG_DATA_W'(unstable));
    endtask

    initial
    begin : stimulus
        longint directed [] = '{SAMPLE_MAX, SAMPLE_MIN, 0, 0, 1, -1, -1, SAMPLE_MAX,
                                SAMPLE_MAX, SAMPLE_MIN, 24'h555555, -24'sh555556, 256,
                                512, 512, 300, -300, 0, SAMPLE_MAX, 1000, 999, 999,
                                -8000000, 8000000, 0};
        items_sent = 0;
        walk_price = 0;
        tx_burst   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) send_sample(directed[i]);
        run_phase(20);
        drain();

        configure(1, 2, 0);
        run_phase(40);
        drain();
        configure(0, 1, 0);
        run_phase(20);
        drain();
        configure(1024, 2, 0);
        run_phase(15);
        drain();
        configure(2, 400, 5);
        run_phase(275);
        drain();
        configure(3, 40, 1);
        run_phase(50);
        drain();
        configure(2047, 511, 65535);
        run_phase(10);
        drain();
        configure(1, 2, 0);
        run_phase(8);
        drain();
        write_register(CFG_UNUSED, 16'hFFFF);
        run_phase(8);
        drain();
        repeat (4) begin
            configure($urandom_range(1, 20), $urandom_range(2, 16), $urandom_range(0, 10));
            run_phase(20);
            drain();
        end

        $display("Sent %0d samples over 13 register settings; %0d index values checked.",
                 items_sent, sb.matched);
        if (sb.errors == 0 && sb.rvi_queue.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
